@@ sv/imme_pkg.sv @@
// Shared types and constants of the int8 matrix multiply engine.
// Holds the command type passed from the front end to the compute back end and the job size type.
// No dependencies.
`default_nettype none

package imme_pkg;

  // Store geometry and field widths
  localparam int StoreDepth = 128;
  localparam int AddrW      = 7;
  localparam int ValW       = 8;
  localparam int RowCountW  = 4;
  localparam int VecLenW    = 5;
  localparam int FilCountW  = 4;
  localparam int NumW       = 3;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 5;
  localparam int QueueDepth = 4;

  // Defaults of the top-level parameters
  localparam int DefMaxRows    = 8;
  localparam int DefMaxVector  = 16;
  localparam int DefMaxFilters = 8;

  // Command codes carried by the input channel
  typedef enum logic [1:0] {
    OP_LOAD_ACT = 2'd0,
    OP_LOAD_FLT = 2'd1,
    OP_START    = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_COUNT     = 2'd0,
    CFG_VECTOR_LENGTH = 2'd1,
    CFG_FILTER_COUNT  = 2'd2
  } cfg_index_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

  // One queued command
  typedef struct packed {
    opcode_t          op;
    logic [AddrW-1:0] idx;
    logic [ValW-1:0]  val;
  } cmd_t;

  // Job sizes as written by software
  typedef struct packed {
    logic [RowCountW-1:0] rows;
    logic [VecLenW-1:0]   len;
    logic [FilCountW-1:0] fils;
  } job_cfg_t;

endpackage

`default_nettype wire

@@ sv/imme_front.sv @@
// Front end of the int8 matrix multiply engine: accepts input transfers,
// drops unknown opcodes and queues commands for the back end. Uses imme_pkg.
`default_nettype none

module imme_front
  import imme_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_opcode,
  input  wire logic [AddrW-1:0] in_element_index,
  input  wire logic [ValW-1:0]  in_element_value,
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  wire logic             q_pop
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            q_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            in_fire;
  logic            known_op;
  logic            push;
  logic            pop;

  // Classify: only the three defined opcodes enter the queue
  assign known_op = (in_opcode == OP_LOAD_ACT) || (in_opcode == OP_LOAD_FLT) ||
                    (in_opcode == OP_START);
  assign in_stall = (count_r == CntW'(QueueDepth));
  assign in_fire  = in_valid && !in_stall;
  assign push     = in_fire && known_op;
  assign pop      = q_pop && q_valid;

  assign q_valid = (count_r != '0);
  assign q_cmd   = q_mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{op: opcode_t'(in_opcode), idx: in_element_index,
                           val: in_element_value};
    end
  end

endmodule

`default_nettype wire

@@ sv/imme_back.sv @@
// Back end of the int8 matrix multiply engine: operand stores, dot-product
// sequencer, multiply-accumulate stage and result register. Uses imme_pkg.
`default_nettype none

module imme_back
  import imme_pkg::*;
#(
  parameter int MAX_ROWS    = DefMaxRows,
  parameter int MAX_VECTOR  = DefMaxVector,
  parameter int MAX_FILTERS = DefMaxFilters
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire job_cfg_t        job_cfg,
  input  wire logic            q_valid,
  input  wire cmd_t            q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [ValW-1:0]      out_product_value,
  output logic [NumW-1:0]      out_row_number,
  output logic [NumW-1:0]      out_filter_number,
  output logic                 out_last_result
);

  bk_state_t state_r, state_nxt;

  logic [ValW-1:0] act_mem [StoreDepth];
  logic [ValW-1:0] flt_mem [StoreDepth];

  // Job sizes and loop counters
  logic [RowCountW-1:0] rows_r, rows_nxt, rows_clamp;
  logic [VecLenW-1:0]   len_r, len_nxt, len_clamp;
  logic [FilCountW-1:0] fils_r, fils_nxt, fils_clamp;
  logic [RowCountW-1:0] r_r, r_nxt;
  logic [FilCountW-1:0] f_r, f_nxt;
  logic [VecLenW-1:0]   k_r, k_nxt;
  logic [AddrW-1:0]     rbase_r, rbase_nxt;
  logic [AddrW-1:0]     fbase_r, fbase_nxt;
  logic                 start_ok;
  logic                 take_start;
  logic                 issue_en;
  logic                 issue_fire;
  logic                 k_last, f_last, r_last, last_issue;
  logic [AddrW-1:0]     act_rd_addr, flt_addr;

  // Read stage
  logic                 rd_valid_r;
  logic                 rd_first_r;
  logic                 rd_klast_r;
  logic                 rd_zero_r;
  logic                 rd_last_r;
  logic [NumW-1:0]      rd_row_r;
  logic [NumW-1:0]      rd_fil_r;
  logic [ValW-1:0]      act_q_r;
  logic [ValW-1:0]      flt_q_r;

  // Accumulate and result
  logic [2*ValW-1:0]    prod_full;
  logic [ValW-1:0]      prod;
  logic [ValW-1:0]      acc_r, acc_sum;
  logic                 out_free;
  logic                 hold;
  logic                 out_valid_r;
  logic [ValW-1:0]      out_value_r;
  logic [NumW-1:0]      out_row_r;
  logic [NumW-1:0]      out_fil_r;
  logic                 out_last_r;

  // Saturate the job sizes at the configured maxima
  assign rows_clamp = (32'(job_cfg.rows) > MAX_ROWS) ? RowCountW'(MAX_ROWS) : job_cfg.rows;
  assign len_clamp  = (32'(job_cfg.len) > MAX_VECTOR) ? VecLenW'(MAX_VECTOR) : job_cfg.len;
  assign fils_clamp = (32'(job_cfg.fils) > MAX_FILTERS) ?
                      FilCountW'(MAX_FILTERS) : job_cfg.fils;
  assign start_ok   = (rows_clamp != '0) && (fils_clamp != '0);

  // Stall the pipe when a finished sum cannot enter the result register
  assign out_free   = !out_valid_r || !out_stall;
  assign hold       = rd_valid_r && rd_klast_r && !out_free;
  assign issue_fire = issue_en && !hold;

  assign k_last      = (len_r == '0) || (k_r + VecLenW'(1) == len_r);
  assign f_last      = (f_r + FilCountW'(1) == fils_r);
  assign r_last      = (r_r + RowCountW'(1) == rows_r);
  assign last_issue  = k_last && f_last && r_last;
  assign act_rd_addr = rbase_r + AddrW'(k_r);
  assign flt_addr    = fbase_r + AddrW'(k_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && (q_cmd.op == OP_START) && start_ok) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue_fire && last_issue) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!rd_valid_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    issue_en = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_pop    = q_valid;
      BK_RUN:   issue_en = 1'b1;
      BK_DRAIN: issue_en = 1'b0;
      default:  issue_en = 1'b0;
    endcase
  end

  assign take_start = q_pop && (q_cmd.op == OP_START) && start_ok;

  // Step k inside f inside r, keeping running store bases
  always_comb begin
    rows_nxt  = rows_r;
    len_nxt   = len_r;
    fils_nxt  = fils_r;
    r_nxt     = r_r;
    f_nxt     = f_r;
    k_nxt     = k_r;
    rbase_nxt = rbase_r;
    fbase_nxt = fbase_r;
    if (take_start) begin
      rows_nxt  = rows_clamp;
      len_nxt   = len_clamp;
      fils_nxt  = fils_clamp;
      r_nxt     = '0;
      f_nxt     = '0;
      k_nxt     = '0;
      rbase_nxt = '0;
      fbase_nxt = '0;
    end else if (issue_fire) begin
      if (!k_last) begin
        k_nxt = k_r + VecLenW'(1);
      end else begin
        k_nxt = '0;
        if (!f_last) begin
          f_nxt     = f_r + FilCountW'(1);
          fbase_nxt = fbase_r + AddrW'(len_r);
        end else begin
          f_nxt     = '0;
          fbase_nxt = '0;
          r_nxt     = r_r + RowCountW'(1);
          rbase_nxt = rbase_r + AddrW'(len_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      rd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!hold) begin
        rd_valid_r <= issue_fire;
      end
      if (rd_valid_r && rd_klast_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters and read-stage tags
  always_ff @(posedge clk) begin
    rows_r  <= rows_nxt;
    len_r   <= len_nxt;
    fils_r  <= fils_nxt;
    r_r     <= r_nxt;
    f_r     <= f_nxt;
    k_r     <= k_nxt;
    rbase_r <= rbase_nxt;
    fbase_r <= fbase_nxt;
    if (issue_fire) begin
      rd_first_r <= (k_r == '0);
      rd_klast_r <= k_last;
      rd_zero_r  <= (len_r == '0);
      rd_last_r  <= last_issue;
      rd_row_r   <= r_r[NumW-1:0];
      rd_fil_r   <= f_r[NumW-1:0];
    end
  end

  // Activation store
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_LOAD_ACT)) begin
      act_mem[q_cmd.idx] <= q_cmd.val;
    end
    if (issue_fire) begin
      act_q_r <= act_mem[act_rd_addr];
    end
  end

  // Filter store
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_LOAD_FLT)) begin
      flt_mem[q_cmd.idx] <= q_cmd.val;
    end
    if (issue_fire) begin
      flt_q_r <= flt_mem[flt_addr];
    end
  end

  // Multiply and accumulate modulo 256
  assign prod_full = act_q_r * flt_q_r;
  assign prod      = rd_zero_r ? '0 : prod_full[ValW-1:0];
  assign acc_sum   = rd_first_r ? prod : acc_r + prod;

  always_ff @(posedge clk) begin
    if (rd_valid_r && !hold) begin
      acc_r <= acc_sum;
    end
    if (rd_valid_r && rd_klast_r && out_free) begin
      out_value_r <= acc_sum;
      out_row_r   <= rd_row_r;
      out_fil_r   <= rd_fil_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_row_number    = out_row_r;
  assign out_filter_number = out_fil_r;
  assign out_last_result   = out_last_r;

  // The read stage is empty whenever the sequencer is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_IDLE |-> !rd_valid_r)
    else $error("read stage busy while sequencer idle");

  // A blocked sum stays in the read stage
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> rd_valid_r && rd_klast_r)
    else $error("blocked sum lost");

  // Loop counters stay inside the job while running
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RUN |-> (r_r < rows_r) && (f_r < fils_r) &&
                          ((len_r == '0) || (k_r < len_r)))
    else $error("loop counter out of range");

  // The final sum only ever completes after issuing has ended
  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && rd_klast_r && rd_last_r && !hold) |-> state_r == BK_DRAIN)
    else $error("final result while still issuing");

endmodule

`default_nettype wire

@@ sv/int8_matrix_multiply_engine_top.sv @@
// Top level of the int8 matrix multiply engine: configuration registers,
// front-end command queue and compute back end. Uses imme_pkg, imme_front, imme_back.
//
// Usage:
//   Input channel (in_valid/in_stall): opcode 0 writes an activation byte,
//   opcode 1 a filter byte, at element_index; opcode 2 starts a job; opcode 3
//   is dropped. The front queue holds four commands and takes one transfer per
//   cycle while it has room.
//   Output channel (out_valid/out_stall): one transfer per row/filter pair, in
//   row-major order, the final one with out_last_result set.
//   Configuration (cfg_write_en/cfg_index/cfg_data): row count, vector length,
//   filter count; write only while the engine is idle. All reset to 1.
// Processing: loads and starts leave the queue while the back end is idle. A start
//   makes rows * filters * max(vector_length, 1) store reads, one store read per
//   cycle unless a stalled result holds the sequencer, through the
//   multiply-accumulate stage into the result register.
// Reset clears the queue, the sequencer and the result register; the operand
//   stores are not cleared. A stalled result holds, and the sequencer stops
//   reading until the result register frees up.
`default_nettype none

module int8_matrix_multiply_engine_top
  import imme_pkg::*;
#(
  parameter int MAX_ROWS    = DefMaxRows,
  parameter int MAX_VECTOR  = DefMaxVector,
  parameter int MAX_FILTERS = DefMaxFilters
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_write_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [AddrW-1:0]    in_element_index,
  input  wire logic [ValW-1:0]     in_element_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ValW-1:0]          out_product_value,
  output logic [NumW-1:0]          out_row_number,
  output logic [NumW-1:0]          out_filter_number,
  output logic                     out_last_result
);

  job_cfg_t job_cfg_r;
  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cfg_r.rows <= RowCountW'(1);
      job_cfg_r.len  <= VecLenW'(1);
      job_cfg_r.fils <= FilCountW'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:     job_cfg_r.rows <= cfg_data[RowCountW-1:0];
        CFG_VECTOR_LENGTH: job_cfg_r.len  <= cfg_data[VecLenW-1:0];
        CFG_FILTER_COUNT:  job_cfg_r.fils <= cfg_data[FilCountW-1:0];
        default:           job_cfg_r      <= job_cfg_r;
      endcase
    end
  end

  imme_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  imme_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_VECTOR  (MAX_VECTOR),
    .MAX_FILTERS (MAX_FILTERS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_cfg           (job_cfg_r),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_row_number    (out_row_number),
    .out_filter_number (out_filter_number),
    .out_last_result   (out_last_result)
  );

endmodule

`default_nettype wire

@@ sim/imme_product_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the int8 matrix multiply engine: follows register writes and
// input transfers, predicts every dot product and compares result transfers in order.
// Depends on imme_pkg.
module imme_product_checker
  import imme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [AddrW-1:0]    in_element_index,
  input  logic [ValW-1:0]     in_element_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [ValW-1:0]     out_product_value,
  input  logic [NumW-1:0]     out_row_number,
  input  logic [NumW-1:0]     out_filter_number,
  input  logic                out_last_result,
  output int                  pending_products,
  output int                  fail_count
);

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [NumW-1:0] row;
    logic [NumW-1:0] filter;
    logic            last;
  } product_t;

  logic [ValW-1:0]      act_bytes [StoreDepth];
  logic [ValW-1:0]      flt_bytes [StoreDepth];
  logic [RowCountW-1:0] row_count = 1;
  logic [VecLenW-1:0]   vec_len = 1;
  logic [FilCountW-1:0] filter_count = 1;
  product_t             expected_q [$];
  int                   mismatches = 0;

  initial pending_products = 0;

  // Leftover expectations count as failures too
  assign fail_count = mismatches + pending_products;

  function automatic int saturate(int v, int limit);
    return (v > limit) ? limit : v;
  endfunction

  // Expand one start into all row/filter dot products, row-major
  task automatic queue_products();
    int       rows, len, fils, r, f, k;
    logic [ValW-1:0] acc;
    product_t p;
    rows = saturate(row_count, DefMaxRows);
    len  = saturate(vec_len, DefMaxVector);
    fils = saturate(filter_count, DefMaxFilters);
    for (r = 0; r < rows; r++) begin
      for (f = 0; f < fils; f++) begin
        acc = '0;
        for (k = 0; k < len; k++) begin
          acc = acc + act_bytes[(r * len + k) % StoreDepth] *
                      flt_bytes[(f * len + k) % StoreDepth];
        end
        p.value  = acc;
        p.row    = r[NumW-1:0];
        p.filter = f[NumW-1:0];
        p.last   = (r == rows - 1) && (f == fils - 1);
        expected_q.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin
    product_t got, want;
    if (!rst_n) begin
      row_count    = 1;
      vec_len      = 1;
      filter_count = 1;
      expected_q.delete();
    end else begin
      // Compare a result transfer with the oldest expectation
      if (out_valid && !out_stall) begin
        got = '{out_product_value, out_row_number, out_filter_number, out_last_result};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: product %0d row %0d filter %0d last %0b",
                     got.value, got.row, got.filter, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected product %0d row %0d filter %0d last %0b, got product %0d row %0d filter %0d last %0b",
                       want.value, want.row, want.filter, want.last,
                       got.value, got.row, got.filter, got.last);
          end
        end
      end
      // Follow register writes
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_ROW_COUNT:     row_count    = cfg_data[RowCountW-1:0];
          CFG_VECTOR_LENGTH: vec_len      = cfg_data[VecLenW-1:0];
          CFG_FILTER_COUNT:  filter_count = cfg_data[FilCountW-1:0];
          default: ;
        endcase
      end
      // Apply an input transfer; unknown opcodes are dropped
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LOAD_ACT: act_bytes[in_element_index] = in_element_value;
          OP_LOAD_FLT: flt_bytes[in_element_index] = in_element_value;
          OP_START:    queue_products();
          default: ;
        endcase
      end
    end
    pending_products <= expected_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the int8 matrix multiply engine: clock, reset, register writes,
// load/start stimulus and the verdict. Depends on imme_pkg, the engine top and imme_product_checker.
module tb;
  import imme_pkg::*;

  localparam logic [1:0] OpIgnored = 2'd3;
  localparam int RandomItems  = 220;
  localparam int SettleCycles = 40;
  localparam int CycleLimit   = 2000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_write_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic [1:0]          in_opcode = '0;
  logic [AddrW-1:0]    in_element_index = '0;
  logic [ValW-1:0]     in_element_value = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [ValW-1:0]     out_product_value;
  logic [NumW-1:0]     out_row_number;
  logic [NumW-1:0]     out_filter_number;
  logic                out_last_result;
  int                  pending_products;
  int                  fail_count;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int job_rows = 1;
  int job_len = 1;
  int job_fils = 1;
  bit act_written [StoreDepth];
  bit flt_written [StoreDepth];

  int8_matrix_multiply_engine_top dut (.*);

  imme_product_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random backpressure on the result channel
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Hard stop on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [1:0] op, logic [AddrW-1:0] idx, logic [ValW-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_element_index <= idx;
    in_element_value <= val;
    do @(posedge clk); while (in_stall);
    if (op != OpIgnored) items_sent++;
  endtask

  task automatic load_byte(bit to_filter, logic [AddrW-1:0] idx, logic [ValW-1:0] val);
    if (to_filter) flt_written[idx] = 1'b1;
    else act_written[idx] = 1'b1;
    send_item(to_filter ? OP_LOAD_FLT : OP_LOAD_ACT, idx, val);
  endtask

  function automatic logic [ValW-1:0] random_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hff;
    return ValW'($urandom);
  endfunction

  // Hold the input idle until every result is in and the back end has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_products != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all three job sizes while the engine is idle
  task automatic configure(int rows, int len, int fils);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_ROW_COUNT;
    cfg_data     <= CfgDataW'(rows);
    @(posedge clk);
    cfg_index    <= CFG_VECTOR_LENGTH;
    cfg_data     <= CfgDataW'(len);
    @(posedge clk);
    cfg_index    <= CFG_FILTER_COUNT;
    cfg_data     <= CfgDataW'(fils);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    job_rows = (rows > DefMaxRows) ? DefMaxRows : rows;
    job_len  = (len > DefMaxVector) ? DefMaxVector : len;
    job_fils = (fils > DefMaxFilters) ? DefMaxFilters : fils;
  endtask

  // Load every operand the job reads that was never written, then start it
  task automatic start_job();
    int r, k, idx;
    if (job_rows > 0 && job_fils > 0) begin
      for (r = 0; r < job_rows; r++) begin
        for (k = 0; k < job_len; k++) begin
          idx = (r * job_len + k) % StoreDepth;
          if (!act_written[idx]) load_byte(1'b0, AddrW'(idx), random_byte());
        end
      end
      for (r = 0; r < job_fils; r++) begin
        for (k = 0; k < job_len; k++) begin
          idx = (r * job_len + k) % StoreDepth;
          if (!flt_written[idx]) load_byte(1'b1, AddrW'(idx), random_byte());
        end
      end
    end
    send_item(OP_START, AddrW'($urandom), ValW'($urandom));
  endtask

  // Mostly small sizes, sometimes zero, the maximum or above it
  function automatic int pick_count(int cap, int all_ones);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 0;
    if (roll < 16) return cap;
    if (roll < 22) return all_ones;
    if (roll < 28) return $urandom_range(all_ones, cap + 1);
    return $urandom_range(1, (cap > 8) ? 5 : 3);
  endfunction

  initial begin
    int  base, phase, roll;
    bit  first_job;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, ignored opcode, top index, zero and saturated sizes
    configure(1, 1, 1);
    load_byte(1'b0, 0, 8'hff);
    load_byte(1'b1, 0, 8'hff);
    start_job();
    send_item(OpIgnored, 7'h7f, 8'hff);
    load_byte(1'b0, 7'h7f, 8'h00);
    load_byte(1'b1, 7'h7f, 8'hff);
    configure(0, 1, 1);
    start_job();
    configure(1, 1, 0);
    start_job();
    configure(2, 0, 2);
    start_job();
    configure(9, 1, 1);
    start_job();

    // Random jobs across three idling regimes
    base = items_sent;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 22; recv_stall_pct = 78; end
        1: begin send_gap_pct = 78; recv_stall_pct = 22; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      first_job = 1'b1;
      while (items_sent - base < RandomItems * (phase + 1) / 3) begin
        if (first_job || $urandom_range(2) == 0)
          configure(pick_count(DefMaxRows, 15), pick_count(DefMaxVector, 31),
                    pick_count(DefMaxFilters, 15));
        first_job = 1'b0;
        repeat ($urandom_range(12)) begin
          roll = $urandom_range(99);
          if (roll < 6)
            send_item(OpIgnored, AddrW'($urandom), ValW'($urandom));
          else if (roll < 14 || job_len == 0 || job_rows == 0 || job_fils == 0)
            load_byte(1'($urandom_range(1)), AddrW'($urandom), random_byte());
          else if ($urandom_range(1))
            load_byte(1'b0, AddrW'($urandom_range(job_rows * job_len - 1)),
                      random_byte());
          else
            load_byte(1'b1, AddrW'($urandom_range(job_fils * job_len - 1)),
                      random_byte());
        end
        start_job();
        if ($urandom_range(4) == 0) start_job();
      end
    end

    wait_drained();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
